@@ rtl/core/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and the step table of the compensation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int FRAC_BITS = 30;
  localparam int OUT_SHIFT = 22;
  localparam int RAW_W     = 24;
  localparam int K_W       = 23;
  // Scale factors are an odd part times 2^19 (codes 0 to 3) or 2^13 (codes
  // 4 to 7), so a Q30 numerator keeps 11 or 17 bits of left shift.
  localparam int SH_COARSE = 11;
  localparam int SH_FINE   = 17;
  localparam int DVD_W     = RAW_W + SH_FINE;
  localparam int QUO_W     = 40;
  localparam int VAL_W     = 64;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  typedef enum logic [2:0] {
    RI_CAL_HI  = 3'd0,
    RI_CAL_MID = 3'd1,
    RI_CAL_LO  = 3'd2,
    RI_P_OSR   = 3'd3,
    RI_T_OSR   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] cal_hi;
    logic [63:0] cal_mid;
    logic [15:0] cal_lo;
    logic [2:0]  p_osr;
    logic [2:0]  t_osr;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_T,
    S_DIV_P,
    S_MUL,
    S_FIN
  } st_t;

  typedef enum logic [2:0] {
    OP_TSC, OP_PSC, OP_TMP, OP_C1, OP_C30, OP_C01, OP_C21
  } opnd_t;

  typedef enum logic [2:0] {
    AD_ZERO, AD_ACC, AD_C0H, AD_C20, AD_C10, AD_C00, AD_C11
  } addend_t;

  typedef enum logic {
    DST_TMP, DST_ACC
  } dst_t;

  typedef struct packed {
    opnd_t   a_sel;
    opnd_t   b_sel;
    logic    rnd;
    addend_t add_sel;
    dst_t    dst;
    logic    last;
  } uop_t;

  localparam logic [2:0] STEP_TEMP  = 3'd0;
  localparam logic [2:0] STEP_PRESS = 3'd1;

  function automatic logic [K_W-1:0] bpc_scale(input logic [2:0] code);
    logic [K_W-1:0] k;
    unique case (code)
      3'd0: k = K_W'(524288);
      3'd1: k = K_W'(1572864);
      3'd2: k = K_W'(3670016);
      3'd3: k = K_W'(7864320);
      3'd4: k = K_W'(253952);
      3'd5: k = K_W'(516096);
      3'd6: k = K_W'(1040384);
      default: k = K_W'(2088960);
    endcase
    return k;
  endfunction

  function automatic uop_t mk_uop(input opnd_t a, input opnd_t b, input logic r,
                                  input addend_t ad, input dst_t d, input logic l);
    uop_t u;
    u.a_sel   = a;
    u.b_sel   = b;
    u.rnd     = r;
    u.add_sel = ad;
    u.dst     = d;
    u.last    = l;
    return u;
  endfunction

  // Temperature uses step 0 only; pressure runs steps 1 to 7.
  function automatic uop_t bpc_uop(input logic [2:0] step);
    uop_t u;
    unique case (step)
      3'd0: u = mk_uop(OP_TSC, OP_C1,  1'b0, AD_C0H,  DST_ACC, 1'b1);
      3'd1: u = mk_uop(OP_PSC, OP_C30, 1'b0, AD_C20,  DST_TMP, 1'b0);
      3'd2: u = mk_uop(OP_TMP, OP_PSC, 1'b1, AD_C10,  DST_TMP, 1'b0);
      3'd3: u = mk_uop(OP_PSC, OP_TMP, 1'b1, AD_C00,  DST_ACC, 1'b0);
      3'd4: u = mk_uop(OP_TSC, OP_C01, 1'b0, AD_ACC,  DST_ACC, 1'b0);
      3'd5: u = mk_uop(OP_PSC, OP_C21, 1'b0, AD_C11,  DST_TMP, 1'b0);
      3'd6: u = mk_uop(OP_PSC, OP_TMP, 1'b1, AD_ZERO, DST_TMP, 1'b0);
      default: u = mk_uop(OP_TSC, OP_TMP, 1'b1, AD_ACC, DST_ACC, 1'b1);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bpc_apb_regs.sv @@
// ----------------------------------------------------------------------------
// bpc_apb_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_apb_regs
  import bpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_hi  <= '0;
      cfg.cal_mid <= '0;
      cfg.cal_lo  <= '0;
      cfg.p_osr   <= 3'd4;
      cfg.t_osr   <= 3'd3;
    end else if (wr) begin
      case (idx)
        RI_CAL_HI:  cfg.cal_hi  <= pwdata;
        RI_CAL_MID: cfg.cal_mid <= pwdata;
        RI_CAL_LO:  cfg.cal_lo  <= pwdata[15:0];
        RI_P_OSR:   cfg.p_osr   <= pwdata[2:0];
        RI_T_OSR:   cfg.t_osr   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RI_CAL_HI:  prdata = cfg.cal_hi;
      RI_CAL_MID: prdata = cfg.cal_mid;
      RI_CAL_LO:  prdata = {48'd0, cfg.cal_lo};
      RI_P_OSR:   prdata = {61'd0, cfg.p_osr};
      RI_T_OSR:   prdata = {61'd0, cfg.t_osr};
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/bpc_div.sv @@
// ----------------------------------------------------------------------------
// bpc_div
// Rounded Q30 scaling of a sample magnitude by its oversampling factor.
// Each factor is (2^m - 1) times a power of two: the power of two is a shift,
// and the odd part is removed by folding the remainder in m-bit digits, one
// fold per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div
  import bpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [RAW_W-1:0] mag,
  input  wire logic [2:0]       code,
  output logic                  done,
  output logic      [QUO_W-1:0] quotient
);

  logic             busy;
  logic [2:0]       code_r;
  logic [7:0]       dvs;
  logic [DVD_W-1:0] num;
  logic [DVD_W-1:0] mask;
  logic [DVD_W-1:0] rem;
  logic [DVD_W-1:0] hi;
  logic [DVD_W-1:0] lo;

  assign dvs = 8'hff >> (3'd7 - code);
  assign num = (code[2] ? {mag, {SH_FINE{1'b0}}}
                        : {{(SH_FINE-SH_COARSE){1'b0}}, mag, {SH_COARSE{1'b0}}})
               + DVD_W'(dvs >> 1);
  assign hi  = rem >> ({1'b0, code_r} + 4'd1);
  assign lo  = rem & mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && hi == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      code_r <= code;
      mask   <= DVD_W'(dvs);
      if (code == 3'd0) begin
        quotient <= QUO_W'(num);
        rem      <= '0;
      end else begin
        quotient <= '0;
        rem      <= num;
      end
    end else if (busy) begin
      if (hi != '0) begin
        quotient <= quotient + QUO_W'(hi);
        rem      <= hi + lo;
      end else if (rem == mask) begin
        quotient <= quotient + QUO_W'(1);
        rem      <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bpc_mul.sv @@
// ----------------------------------------------------------------------------
// bpc_mul
// Shared 64x64 magnitude multiplier built from four 32x32 partial products,
// with an optional rounded shift by the Q30 fraction width.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_mul
  import bpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] a,
  input  wire logic [VAL_W-1:0] b,
  input  wire logic             rnd,
  output logic                  done,
  output logic      [VAL_W-1:0] result
);

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic         rnd_r;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] acc;
  logic [127:0] acc_next;

  assign acc_next = acc + ({64'd0, pp} << {pp_sh, 5'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      rnd_r <= rnd;
      acc   <= rnd ? (128'd1 << (FRAC_BITS - 1)) : '0;
    end else if (busy) begin
      if (cnt != 3'd4) begin
        pp    <= (cnt[0] ? a_r[63:32] : a_r[31:0]) * (cnt[1] ? b_r[63:32] : b_r[31:0]);
        pp_sh <= 2'(cnt[0]) + 2'(cnt[1]);
      end
      if (cnt != 3'd0) begin
        acc <= acc_next;
      end
      if (cnt == 3'd4) begin
        result <= rnd_r ? acc_next[FRAC_BITS +: VAL_W] : acc_next[VAL_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/baro_pressure_temp_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Barometric sensor compensation: scales raw samples by the oversampling
// factor and evaluates the calibration polynomial in Q30 fixed point.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   input    in_valid / in_stall  mode, raw_sample
//   output   out_valid/ out_stall compensated_value, saturated
//   config   APB psel/penable     paddr, pwdata, prdata
//
// Between input beats, a temperature item runs one scaling in the folding
// divider, whose run length is set by the oversampling code, and one product
// on the shared multiplier; a pressure item runs two scalings and seven
// product steps. Then the result is loaded. One item is in work at a time;
// in_stall is high until the result is loaded into the output register,
// which holds it under out_stall. Reset is synchronous.
`default_nettype none

module baro_pressure_temp_compensation_unit
  import bpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              mode,
  input  wire logic [23:0]       raw_sample,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [31:0]     compensated_value,
  output logic                   saturated,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;
  st_t  state, state_next;

  logic              in_beat;
  logic              mode_r;
  logic [23:0]       raw_r;
  logic [23:0]       last_raw_temperature;
  logic              issued;
  logic [2:0]        step;
  uop_t              uop;

  logic signed [63:0] tsc, psc, tmp, acc;

  logic [23:0]       src, src_mag;
  logic [2:0]        osr;
  logic              div_start, div_done, div_neg;
  logic [QUO_W-1:0]  quotient;
  logic [63:0]       q64;

  logic signed [63:0] opa, opb, addend, prod, mul_res;
  logic [63:0]       mag_a, mag_b, mul_mag;
  logic              mul_start, mul_done, mul_neg;

  logic signed [11:0] c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;

  logic              fin_neg, fin_sat, out_load;
  logic [63:0]       fin_mag;
  logic [41:0]       fin_v;
  logic [31:0]       fin_val;

  bpc_apb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign c0  = cfg.cal_hi[63:52];
  assign c1  = cfg.cal_hi[51:40];
  assign c00 = cfg.cal_hi[39:20];
  assign c10 = cfg.cal_hi[19:0];
  assign c01 = cfg.cal_mid[63:48];
  assign c11 = cfg.cal_mid[47:32];
  assign c20 = cfg.cal_mid[31:16];
  assign c21 = cfg.cal_mid[15:0];
  assign c30 = cfg.cal_lo;

  assign in_stall = (state != S_IDLE);
  assign in_beat  = in_valid && !in_stall;

  // Divider operands.
  assign src      = (state == S_DIV_T) ? last_raw_temperature : raw_r;
  assign src_mag  = src[23] ? 24'(-src) : src;
  assign osr      = (state == S_DIV_T) ? cfg.t_osr : cfg.p_osr;
  assign q64      = {{(64-QUO_W){1'b0}}, quotient};

  bpc_div u_div (
    .clk, .rst, .start(div_start), .mag(src_mag), .code(osr),
    .done(div_done), .quotient
  );

  // Multiplier operands for the current step.
  assign uop = bpc_uop(step);

  function automatic logic signed [63:0] pick(input opnd_t sel,
      input logic signed [63:0] t, input logic signed [63:0] p,
      input logic signed [63:0] m, input logic signed [11:0] k1,
      input logic signed [15:0] k30, input logic signed [15:0] k01,
      input logic signed [15:0] k21);
    logic signed [63:0] v;
    unique case (sel)
      OP_TSC:  v = t;
      OP_PSC:  v = p;
      OP_TMP:  v = m;
      OP_C1:   v = 64'(k1);
      OP_C30:  v = 64'(k30);
      OP_C01:  v = 64'(k01);
      default: v = 64'(k21);
    endcase
    return v;
  endfunction

  assign opa   = pick(uop.a_sel, tsc, psc, tmp, c1, c30, c01, c21);
  assign opb   = pick(uop.b_sel, tsc, psc, tmp, c1, c30, c01, c21);
  assign mag_a = opa[63] ? 64'(-opa) : opa;
  assign mag_b = opb[63] ? 64'(-opb) : opb;

  bpc_mul u_mul (
    .clk, .rst, .start(mul_start), .a(mag_a), .b(mag_b), .rnd(uop.rnd),
    .done(mul_done), .result(mul_mag)
  );

  always_comb begin
    unique case (uop.add_sel)
      AD_ZERO: addend = '0;
      AD_ACC:  addend = acc;
      AD_C0H:  addend = {{23{c0[11]}}, c0, 29'd0};
      AD_C20:  addend = {{18{c20[15]}}, c20, 30'd0};
      AD_C10:  addend = {{14{c10[19]}}, c10, 30'd0};
      AD_C00:  addend = {{14{c00[19]}}, c00, 30'd0};
      default: addend = {{18{c11[15]}}, c11, 30'd0};
    endcase
  end

  assign prod    = mul_neg ? 64'(-mul_mag) : mul_mag;
  assign mul_res = addend + prod;

  // Q30 to Q8 with rounding and clamping to 32 bits.
  assign fin_neg = acc[63];
  assign fin_mag = fin_neg ? 64'(-acc) : acc;
  assign fin_v   = 42'((fin_mag + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT);
  assign fin_sat = fin_neg ? (fin_v > 42'h0_8000_0000) : (fin_v > 42'h0_7fff_ffff);
  assign fin_val = fin_sat ? (fin_neg ? 32'h8000_0000 : 32'h7fff_ffff)
                           : (fin_neg ? 32'(-fin_v[31:0]) : fin_v[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_beat) begin
          state_next = S_DIV_T;
        end
      end
      S_DIV_T: begin
        div_start = !issued;
        if (div_done) begin
          state_next = mode_r ? S_DIV_P : S_MUL;
        end
      end
      S_DIV_P: begin
        div_start = !issued;
        if (div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        mul_start = !issued;
        if (mul_done && uop.last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!(out_valid && out_stall)) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued               <= 1'b0;
      out_valid            <= 1'b0;
      last_raw_temperature <= '0;
    end else begin
      if (div_start || mul_start) begin
        issued <= 1'b1;
      end else if (div_done || mul_done) begin
        issued <= 1'b0;
      end
      if (in_beat && !mode) begin
        last_raw_temperature <= raw_sample;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      mode_r <= mode;
      raw_r  <= raw_sample;
      step   <= mode ? STEP_PRESS : STEP_TEMP;
    end
    if (div_start) begin
      div_neg <= src[23];
    end
    if (mul_start) begin
      mul_neg <= opa[63] ^ opb[63];
    end
    if (div_done) begin
      if (state == S_DIV_T) begin
        tsc <= div_neg ? 64'(-q64) : q64;
      end else begin
        psc <= div_neg ? 64'(-q64) : q64;
      end
    end
    if (mul_done) begin
      if (uop.dst == DST_ACC) begin
        acc <= mul_res;
      end else begin
        tmp <= mul_res;
      end
      step <= step + 3'd1;
    end
    if (out_load) begin
      compensated_value <= fin_val;
      saturated         <= fin_sat;
    end
  end

  a_temp_store: assert property (@(posedge clk) disable iff (rst)
    in_beat && !mode |=> last_raw_temperature == $past(raw_sample))
    else $error("temperature sample not stored");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MUL)
    else $error("multiplier finished outside its step");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_T || state == S_DIV_P))
    else $error("divider finished outside a scaling state");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (compensated_value == 32'sh7fff_ffff || compensated_value == 32'sh8000_0000))
    else $error("saturated result is not a range limit");

endmodule

`default_nettype wire
